// ===== rtl/unsf_pkg.sv =====
// Shared types and constants for the binary and text stream framer.
package unsf_pkg;

    typedef enum logic [3:0] {
        ST_HUNT    = 4'd0,
        ST_SYNC    = 4'd1,
        ST_CLASS   = 4'd2,
        ST_ID      = 4'd3,
        ST_LEN1    = 4'd4,
        ST_LEN2    = 4'd5,
        ST_PAYLOAD = 4'd6,
        ST_CK_A    = 4'd7,
        ST_CK_B    = 4'd8,
        ST_TEXT    = 4'd9
    } parse_state_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_FRAMEEND = 2'd1,
        KIND_TEXTCHAR = 2'd2,
        KIND_TEXTEND  = 2'd3
    } out_kind_t;

    localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
    localparam logic [7:0] SYNC_CHAR_2 = 8'h62;
    localparam logic [7:0] TEXT_START  = 8'h24;
    localparam logic [7:0] TEXT_CR     = 8'h0D;
    localparam logic [7:0] TEXT_LF     = 8'h0A;

    typedef struct packed {
        logic        valid;
        out_kind_t   kind;
        logic [7:0]  data;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] length;
        logic        ok;
    } result_t;

endpackage

// ===== rtl/unsf_parser.sv =====
// Frame parser: state, header capture, running check sums and result decode.
module unsf_parser import unsf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    parse_state_t state_reg, state_next;
    logic [7:0]   class_reg, class_next;
    logic [7:0]   id_reg, id_next;
    logic [15:0]  length_reg, length_next;
    logic [15:0]  count_reg, count_next;
    logic [7:0]   sum_a_reg, sum_a_next;
    logic [7:0]   sum_b_reg, sum_b_next;
    logic [7:0]   ck_a_reg, ck_a_next;
    logic [7:0]   add_a;
    logic [7:0]   add_b;
    logic [15:0]  count_inc;
    logic [15:0]  full_length;

    assign add_a       = sum_a_reg + rx_byte;
    assign add_b       = sum_b_reg + add_a;
    assign count_inc   = count_reg + 16'd1;
    assign full_length = {rx_byte, length_reg[7:0]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT: begin
                if (rx_byte == SYNC_CHAR_1) begin
                    state_next = ST_SYNC;
                end else if (rx_byte == TEXT_START) begin
                    state_next = ST_TEXT;
                end
            end
            ST_SYNC:  state_next = (rx_byte == SYNC_CHAR_2) ? ST_CLASS : ST_HUNT;
            ST_CLASS: state_next = ST_ID;
            ST_ID:    state_next = ST_LEN1;
            ST_LEN1:  state_next = ST_LEN2;
            ST_LEN2:  state_next = (full_length != 16'd0) ? ST_PAYLOAD : ST_CK_A;
            ST_PAYLOAD: begin
                if (count_inc >= length_reg) begin
                    state_next = ST_CK_A;
                end
            end
            ST_CK_A: state_next = ST_CK_B;
            ST_CK_B: state_next = ST_HUNT;
            ST_TEXT: begin
                if (rx_byte == TEXT_LF) begin
                    state_next = ST_HUNT;
                end
            end
            default: state_next = ST_HUNT;
        endcase
    end

    always_comb begin
        class_next  = class_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        ck_a_next   = ck_a_reg;
        case (state_reg)
            ST_HUNT: begin
                if (rx_byte == SYNC_CHAR_1) begin
                    class_next  = 8'd0;
                    id_next     = 8'd0;
                    length_next = 16'd0;
                    count_next  = 16'd0;
                    sum_a_next  = 8'd0;
                    sum_b_next  = 8'd0;
                end
            end
            ST_CLASS: begin
                class_next = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
            end
            ST_ID: begin
                id_next    = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
            end
            ST_LEN1: begin
                length_next = {8'd0, rx_byte};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
            end
            ST_LEN2: begin
                length_next = full_length;
                count_next  = 16'd0;
                sum_a_next  = add_a;
                sum_b_next  = add_b;
            end
            ST_PAYLOAD: begin
                count_next = count_inc;
                sum_a_next = add_a;
                sum_b_next = add_b;
            end
            ST_CK_A: ck_a_next = rx_byte;
            default: ;
        endcase
    end

    always_comb begin
        result           = '0;
        result.kind      = KIND_PAYLOAD;
        result.msg_class = class_reg;
        result.msg_id    = id_reg;
        result.length    = length_reg;
        case (state_reg)
            ST_HUNT: begin
                if (rx_byte != SYNC_CHAR_1 && rx_byte == TEXT_START) begin
                    result.valid     = 1'b1;
                    result.kind      = KIND_TEXTCHAR;
                    result.data      = rx_byte;
                end
            end
            ST_PAYLOAD: begin
                result.valid = 1'b1;
                result.kind  = KIND_PAYLOAD;
                result.data  = rx_byte;
            end
            ST_CK_B: begin
                result.valid = 1'b1;
                result.kind  = KIND_FRAMEEND;
                result.ok    = (ck_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
            end
            ST_TEXT: begin
                if (rx_byte == TEXT_LF) begin
                    result.valid = 1'b1;
                    result.kind  = KIND_TEXTEND;
                end else if (rx_byte != TEXT_CR) begin
                    result.valid = 1'b1;
                    result.kind  = KIND_TEXTCHAR;
                    result.data  = rx_byte;
                end
            end
            default: ;
        endcase
        if (result.kind == KIND_TEXTCHAR || result.kind == KIND_TEXTEND) begin
            result.msg_class = 8'd0;
            result.msg_id    = 8'd0;
            result.length    = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_HUNT;
            class_reg  <= 8'd0;
            id_reg     <= 8'd0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            sum_a_reg  <= 8'd0;
            sum_b_reg  <= 8'd0;
            ck_a_reg   <= 8'd0;
        end else if (advance) begin
            state_reg  <= state_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            ck_a_reg   <= ck_a_next;
        end
    end

endmodule

// ===== rtl/ubx_nmea_stream_framer_unit.sv =====
// Top level: binary frame and text sentence framer with registered result word.
// Each result is registered and appears on m_ in the cycle after its input word is accepted.
// Throughput: one input word per cycle, set by the single output register;
// s_ready stays high while the output register is empty or being taken.
// Reset (synchronous, active low) returns the parser to hunting for a start
// byte, clears the frame header and check sums, and empties the output register.
module ubx_nmea_stream_framer_unit import unsf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic [7:0]  m_msg_class,
    output logic [7:0]  m_msg_id,
    output logic [15:0] m_payload_length,
    output logic        m_checksum_ok
);

    result_t result;
    result_t out_reg, out_next;
    logic    accept;

    assign s_ready = !out_reg.valid || m_ready;
    assign accept  = s_valid && s_ready;

    unsf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept),
        .rx_byte (s_rx_byte),
        .result  (result)
    );

    always_comb begin
        out_next = out_reg;
        if (accept) begin
            out_next = result;
        end else if (m_ready) begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else begin
            out_reg <= out_next;
        end
    end

    assign m_valid          = out_reg.valid;
    assign m_out_kind       = out_reg.kind;
    assign m_out_byte       = out_reg.data;
    assign m_msg_class      = out_reg.msg_class;
    assign m_msg_id         = out_reg.msg_id;
    assign m_payload_length = out_reg.length;
    assign m_checksum_ok    = out_reg.ok;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the binary frame and text sentence stream framer.
module tb_top;
    import unsf_pkg::*;

    localparam int unsigned ITEM_TARGET = 1100;
    localparam int unsigned QUIET_TAIL  = 150;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef logic [7:0] byte_q_t[$];

    typedef enum int {
        FLAW_NONE,
        FLAW_CK_A,
        FLAW_CK_B,
        FLAW_CUT_CK_B,
        FLAW_CUT_PAYLOAD
    } frame_flaw_t;

    typedef struct packed {
        out_kind_t   kind;
        logic [7:0]  data;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] length;
        logic        ok;
    } frame_word_t;

    class framer_checker;
        parse_state_t state_q;
        logic [7:0]   class_q;
        logic [7:0]   id_q;
        logic [15:0]  length_q;
        logic [15:0]  count_q;
        logic [7:0]   sum_a_q;
        logic [7:0]   sum_b_q;
        logic [7:0]   ck_a_q;
        frame_word_t  expected_words[$];
        int unsigned  mismatches;
        int unsigned  words_checked;

        function new();
            state_q       = ST_HUNT;
            class_q       = 8'h00;
            id_q          = 8'h00;
            length_q      = 16'h0000;
            count_q       = 16'h0000;
            sum_a_q       = 8'h00;
            sum_b_q       = 8'h00;
            ck_a_q        = 8'h00;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void add_sum(logic [7:0] c);
            sum_a_q = sum_a_q + c;
            sum_b_q = sum_b_q + sum_a_q;
        endfunction

        function void push_word(out_kind_t kind, logic [7:0] data, bit binary, bit ok);
            frame_word_t w;
            w.kind      = kind;
            w.data      = data;
            w.msg_class = binary ? class_q : 8'h00;
            w.msg_id    = binary ? id_q : 8'h00;
            w.length    = binary ? length_q : 16'h0000;
            w.ok        = ok;
            expected_words.push_back(w);
        endfunction

        function void note_rx_byte(logic [7:0] c);
            case (state_q)
                ST_HUNT: begin
                    if (c == SYNC_CHAR_1) begin
                        class_q  = 8'h00;
                        id_q     = 8'h00;
                        length_q = 16'h0000;
                        count_q  = 16'h0000;
                        sum_a_q  = 8'h00;
                        sum_b_q  = 8'h00;
                        state_q  = ST_SYNC;
                    end else if (c == TEXT_START) begin
                        state_q = ST_TEXT;
                        push_word(KIND_TEXTCHAR, c, 1'b0, 1'b0);
                    end
                end
                ST_SYNC: begin
                    state_q = (c == SYNC_CHAR_2) ? ST_CLASS : ST_HUNT;
                end
                ST_CLASS: begin
                    class_q = c;
                    add_sum(c);
                    state_q = ST_ID;
                end
                ST_ID: begin
                    id_q = c;
                    add_sum(c);
                    state_q = ST_LEN1;
                end
                ST_LEN1: begin
                    length_q = {8'h00, c};
                    add_sum(c);
                    state_q = ST_LEN2;
                end
                ST_LEN2: begin
                    length_q = {c, length_q[7:0]};
                    add_sum(c);
                    count_q = 16'h0000;
                    state_q = (length_q != 16'h0000) ? ST_PAYLOAD : ST_CK_A;
                end
                ST_PAYLOAD: begin
                    add_sum(c);
                    count_q = count_q + 16'd1;
                    if (count_q >= length_q) begin
                        state_q = ST_CK_A;
                    end
                    push_word(KIND_PAYLOAD, c, 1'b1, 1'b0);
                end
                ST_CK_A: begin
                    ck_a_q  = c;
                    state_q = ST_CK_B;
                end
                ST_CK_B: begin
                    state_q = ST_HUNT;
                    push_word(KIND_FRAMEEND, 8'h00, 1'b1,
                              (ck_a_q == sum_a_q) && (c == sum_b_q));
                end
                ST_TEXT: begin
                    if (c == TEXT_LF) begin
                        state_q = ST_HUNT;
                        push_word(KIND_TEXTEND, 8'h00, 1'b0, 1'b0);
                    end else if (c != TEXT_CR) begin
                        push_word(KIND_TEXTCHAR, c, 1'b0, 1'b0);
                    end
                end
                default: begin
                    state_q = ST_HUNT;
                end
            endcase
        endfunction

        function void check_word(frame_word_t got);
            frame_word_t want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result word kind %0d byte %02h",
                             got.kind, got.data);
                end
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display({"ERROR: word %0d expected kind %0d byte %02h class %02h",
                              " id %02h len %0d ok %0b"},
                             words_checked, want.kind, want.data, want.msg_class,
                             want.msg_id, want.length, want.ok);
                    $display({"       got      kind %0d byte %02h class %02h",
                              " id %02h len %0d ok %0b"},
                             got.kind, got.data, got.msg_class, got.msg_id,
                             got.length, got.ok);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_out_kind;
    logic [7:0]  m_out_byte;
    logic [7:0]  m_msg_class;
    logic [7:0]  m_msg_id;
    logic [15:0] m_payload_length;
    logic        m_checksum_ok;

    framer_checker chk;
    bit            idle_on;
    int unsigned   cycle_count;
    int unsigned   bytes_sent;
    int unsigned   frames_sent;
    int unsigned   sentences_sent;

    ubx_nmea_stream_framer_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_kind       (m_out_kind),
        .m_out_byte       (m_out_byte),
        .m_msg_class      (m_msg_class),
        .m_msg_id         (m_msg_id),
        .m_payload_length (m_payload_length),
        .m_checksum_ok    (m_checksum_ok)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] fletcher16(input byte_q_t data);
        logic [7:0] a;
        logic [7:0] b;
        a = 8'h00;
        b = 8'h00;
        foreach (data[i]) begin
            a = a + data[i];
            b = b + a;
        end
        return {b, a};
    endfunction

    function automatic byte_q_t random_bytes(input int unsigned n, input bit text);
        byte_q_t     q;
        logic [7:0]  ch;
        int unsigned r;
        for (int unsigned i = 0; i < n; i++) begin
            r  = $urandom_range(0, 9);
            ch = 8'($urandom_range(0, 255));
            if (text) begin
                if (r == 0) begin
                    ch = TEXT_CR;
                end else if (r < 7) begin
                    ch = 8'($urandom_range(8'h20, 8'h7E));
                end else if (ch == TEXT_LF) begin
                    ch = TEXT_START;
                end
            end
            q.push_back(ch);
        end
        return q;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chk.note_rx_byte(b);
        bytes_sent++;
        if (bytes_sent >= ITEM_TARGET - QUIET_TAIL) begin
            idle_on = 1'b0;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input byte_q_t body, input frame_flaw_t flaw);
        byte_q_t     summed;
        logic [15:0] len;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        int unsigned n_send;
        len    = 16'(body.size());
        summed = {cls, id, len[7:0], len[15:8]};
        summed = {summed, body};
        {ck_b, ck_a} = fletcher16(summed);
        if (flaw == FLAW_CK_A) begin
            ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
        end
        if (flaw == FLAW_CK_B) begin
            ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
        end
        send_byte(SYNC_CHAR_1);
        send_byte(SYNC_CHAR_2);
        send_byte(cls);
        send_byte(id);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        n_send = (flaw == FLAW_CUT_PAYLOAD && body.size() > 0) ? body.size() - 1 : body.size();
        for (int unsigned i = 0; i < n_send; i++) begin
            send_byte(body[i]);
        end
        if (flaw != FLAW_CUT_PAYLOAD) begin
            send_byte(ck_a);
            if (flaw != FLAW_CUT_CK_B) begin
                send_byte(ck_b);
            end
        end
        frames_sent++;
    endtask

    task automatic send_sentence(input byte_q_t body, input bit with_cr);
        send_byte(TEXT_START);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
        if (with_cr) begin
            send_byte(TEXT_CR);
        end
        send_byte(TEXT_LF);
        sentences_sent++;
    endtask

    // result side: random stall bursts while idling is on
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                chk.check_word({out_kind_t'(m_out_kind), m_out_byte, m_msg_class,
                                m_msg_id, m_payload_length, m_checksum_ok});
            end
            if (!idle_on) begin
                stall_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        byte_q_t     none;
        byte_q_t     body;
        int unsigned pick;
        int unsigned len;
        int unsigned next_drain;
        frame_flaw_t flaw;

        chk            = new();
        bytes_sent     = 0;
        frames_sent    = 0;
        sentences_sent = 0;
        next_drain     = 250;
        idle_on        = 1'b1;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= 8'h00;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ignored bytes, empty frame, bad sync, sentence, bad checksum
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'hFF, 8'h00, none, FLAW_NONE);
        send_byte(SYNC_CHAR_1);
        send_byte(SYNC_CHAR_1);
        send_byte(SYNC_CHAR_2);
        body = {TEXT_START, SYNC_CHAR_1};
        send_sentence(body, 1'b1);
        wait_drained();
        body = {8'hAA};
        send_frame(8'h01, 8'h02, body, FLAW_CK_B);

        while (bytes_sent < ITEM_TARGET) begin
            idle_on = (bytes_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 16);
                body = random_bytes(len, 1'b0);
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           body, FLAW_NONE);
            end else if (pick < 55) begin
                body = random_bytes($urandom_range(0, 16), 1'b0);
                flaw = ($urandom_range(0, 1) == 0) ? FLAW_CK_A : FLAW_CK_B;
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           body, flaw);
            end else if (pick < 80) begin
                body = random_bytes($urandom_range(0, 20), 1'b1);
                send_sentence(body, 1'($urandom_range(0, 1)));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 5)) begin
                    body = random_bytes(1, 1'b0);
                    if (body[0] != SYNC_CHAR_1 && body[0] != TEXT_START) begin
                        send_byte(body[0]);
                    end
                end
            end else if (pick < 95) begin
                body = random_bytes(1, 1'b0);
                send_byte(SYNC_CHAR_1);
                send_byte((body[0] == SYNC_CHAR_2) ? ~SYNC_CHAR_2 : body[0]);
            end else begin
                body = random_bytes($urandom_range(1, 16), 1'b0);
                flaw = ($urandom_range(0, 1) == 0) ? FLAW_CUT_CK_B : FLAW_CUT_PAYLOAD;
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           body, flaw);
            end
            if (bytes_sent >= next_drain) begin
                wait_drained();
                next_drain = next_drain + 250;
            end
        end

        idle_on = 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes: %0d binary frames (some flawed), %0d text sentences,",
                 bytes_sent, frames_sent, sentences_sent);
        $display("plus noise and broken sync; %0d result words checked, %0d bad, %0d left over",
                 chk.words_checked, chk.mismatches, chk.pending());
        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
